// ----- rtl/frustum_box_cull_unit_assert.svh -----
// Assertion macros for the frustum box cull unit.
`ifndef FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FBC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define FBC_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define FBC_ASSERT_IMP(label, clk, rst, a, c)
`define FBC_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ----- rtl/fbc_pkg.sv -----
package fbc_pkg;
   localparam int FRAC_BITS = 16;
   localparam int NUM_CELLS = 8;
   localparam int NUM_REGS = 8;
   localparam int ACC_W = 68;
   localparam int IDX_W = 3;

   typedef struct packed {
      logic signed [31:0] lo_x;
      logic signed [31:0] lo_y;
      logic signed [31:0] lo_z;
      logic signed [31:0] hi_x;
      logic signed [31:0] hi_y;
      logic signed [31:0] hi_z;
   } box_type;

   // Sticky flags carried along the chain.
   typedef struct packed {
      logic x_lt;
      logic x_gt;
      logic y_lt;
      logic y_gt;
      logic z_lt;
      logic z_gt;
   } flags_type;

   typedef struct packed {
      logic      valid;
      box_type   box;
      flags_type flags;
   } beat_type;
endpackage

// ----- rtl/fbc_corner_cell.sv -----
`include "frustum_box_cull_unit_assert.svh"
// One corner per cell: four row dot products in stage one, compares in
// stage two, then the beat moves to the next cell.
module fbc_corner_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [fbc_pkg::IDX_W-1:0] corner,
   input  logic [32*16-1:0]          mat,
   input  fbc_pkg::beat_type         beat_i,
   output fbc_pkg::beat_type         beat_o
);
   fbc_pkg::beat_type mid_ff, mid_in, out_ff, out_in;
   logic signed [fbc_pkg::ACC_W-1:0] dot_ff [4];
   logic signed [fbc_pkg::ACC_W-1:0] dot_in [4];
   logic signed [31:0] px, py, pz;
   logic signed [fbc_pkg::ACC_W-1:0] aw, naw, wv;

   function automatic logic signed [fbc_pkg::ACC_W-1:0] ACC_EXT(input logic signed [63:0] v);
      ACC_EXT = fbc_pkg::ACC_W'(v);
   endfunction

   assign px = corner[0] ? beat_i.box.hi_x : beat_i.box.lo_x;
   assign py = corner[1] ? beat_i.box.hi_y : beat_i.box.lo_y;
   assign pz = corner[2] ? beat_i.box.hi_z : beat_i.box.lo_z;

   // Row dot products with the homogeneous one.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         dot_in[r] = ACC_EXT(signed'(mat[(r*4+0)*32 +: 32]) * px)
            + ACC_EXT(signed'(mat[(r*4+1)*32 +: 32]) * py)
            + ACC_EXT(signed'(mat[(r*4+2)*32 +: 32]) * pz)
            + ACC_EXT(64'(signed'(mat[(r*4+3)*32 +: 32])) <<< fbc_pkg::FRAC_BITS);
      end
      mid_in = beat_i;
   end

   // Compare stage folds this corner into the sticky flags.
   always_comb begin
      wv = dot_ff[3];
      aw = wv[fbc_pkg::ACC_W-1] ? -wv : wv;
      naw = -aw;
      out_in = mid_ff;
      out_in.flags.x_lt = mid_ff.flags.x_lt | (dot_ff[0] < aw);
      out_in.flags.x_gt = mid_ff.flags.x_gt | (naw < dot_ff[0]);
      out_in.flags.y_lt = mid_ff.flags.y_lt | (dot_ff[1] < aw);
      out_in.flags.y_gt = mid_ff.flags.y_gt | (naw < dot_ff[1]);
      out_in.flags.z_lt = mid_ff.flags.z_lt | (dot_ff[2] < aw);
      out_in.flags.z_gt = mid_ff.flags.z_gt | (dot_ff[2] > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_ff <= mid_in;
         out_ff <= out_in;
         for (int r = 0; r < 4; r++) begin
            dot_ff[r] <= dot_in[r];
         end
      end
   end

   assign beat_o = out_ff;

   `FBC_ASSERT_NXT(a_hold, clock, reset, !advance, $stable(out_ff.valid))
   `FBC_ASSERT_NXT(a_move, clock, reset, advance, out_ff.valid == $past(mid_ff.valid))
   `FBC_ASSERT_NXT(a_sticky, clock, reset, advance && mid_ff.flags.z_gt,
      out_ff.flags.z_gt)
endmodule

// ----- rtl/frustum_box_cull_unit.sv -----
// Path: each accepted request beat passes through two register stages in
// each of eight corner cells before it becomes the response beat.
// Throughput: one box per cycle while the chain advances.
// The chain stalls as a whole while the response is held back.
// Reset: synchronous, active high; clears the matrix and all valid flags.
`include "frustum_box_cull_unit_assert.svh"
module frustum_box_cull_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: culled, then zero fill
   output logic [7:0]   rsp_tdata
);
   logic [63:0] regs_ff [fbc_pkg::NUM_REGS];
   logic [32*16-1:0] mat;
   fbc_pkg::beat_type chain [fbc_pkg::NUM_CELLS+1];
   logic advance;
   fbc_pkg::flags_type f;

   // Matrix registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fbc_pkg::NUM_REGS; i++) regs_ff[i] <= '0;
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   // Entry (row r, col c) sits at slot r*4+c.
   always_comb begin
      for (int i = 0; i < fbc_pkg::NUM_REGS; i++) begin
         mat[i*64 +: 64] = regs_ff[i];
      end
   end

   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      chain[0].valid = req_tvalid;
      chain[0].box.lo_x = req_tdata[31:0];
      chain[0].box.lo_y = req_tdata[63:32];
      chain[0].box.lo_z = req_tdata[95:64];
      chain[0].box.hi_x = req_tdata[127:96];
      chain[0].box.hi_y = req_tdata[159:128];
      chain[0].box.hi_z = req_tdata[191:160];
      chain[0].flags = '0;
   end

   for (genvar k = 0; k < fbc_pkg::NUM_CELLS; k++) begin : g_cell
      fbc_corner_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .corner(fbc_pkg::IDX_W'(k)), .mat(mat),
         .beat_i(chain[k]), .beat_o(chain[k+1])
      );
   end

   assign f = chain[fbc_pkg::NUM_CELLS].flags;
   assign rsp_tvalid = chain[fbc_pkg::NUM_CELLS].valid;
   assign rsp_tdata = {7'b0,
      !(f.x_lt && f.x_gt && f.y_lt && f.y_gt && f.z_lt && f.z_gt)};

   `FBC_ASSERT_IMP(a_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `FBC_ASSERT_NXT(a_keep, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `FBC_ASSERT_NXT(a_data, clock, reset, rsp_tvalid && !rsp_tready,
      $stable(rsp_tdata))
endmodule
